/* rtl/apm_pkg.sv */
package apm_pkg;

  // Field widths fixed by the block's register map and result format.
  localparam int COUNT_W   = 16;
  localparam int DELTA_W   = 10;
  localparam int CURRENT_W = 15;
  localparam int MODE_W    = 3;
  localparam int POWER_W   = 3;
  localparam int PHASE_W   = 5;
  localparam int CFG_AW    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int APB_DW    = 32;

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(29);

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_STARTUP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MONITOR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOW     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMERG   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAINT   = 3'd4;

  // Power level codes.
  localparam logic [POWER_W-1:0] PWR_ACTIVE = 3'd0;
  localparam logic [POWER_W-1:0] PWR_IDLE   = 3'd1;
  localparam logic [POWER_W-1:0] PWR_SENSOR = 3'd2;
  localparam logic [POWER_W-1:0] PWR_DEEP   = 3'd3;
  localparam logic [POWER_W-1:0] PWR_EMERG  = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EMERG_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MON_TEMP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MON_LIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MON_ACCEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_TEMP  = 3'd7;

  // Register reset values.
  localparam logic [COUNT_W-1:0] RST_EMERG_LIMIT  = 16'd2;
  localparam logic [COUNT_W-1:0] RST_LOW_LIMIT    = 16'd5;
  localparam logic [DELTA_W-1:0] RST_MON_TEMP     = 10'd50;
  localparam logic [DELTA_W-1:0] RST_MON_LIGHT    = 10'd100;
  localparam logic [DELTA_W-1:0] RST_MON_ACCEL    = 10'd80;
  localparam logic [DELTA_W-1:0] RST_LOW_TEMP     = 10'd100;
  localparam logic [DELTA_W-1:0] RST_LOW_LIGHT    = 10'd150;
  localparam logic [DELTA_W-1:0] RST_RECOVER_TEMP = 10'd200;

  typedef struct packed {
    logic [COUNT_W-1:0] emergency_limit;
    logic [COUNT_W-1:0] low_activity_limit;
    logic [DELTA_W-1:0] mon_temp_delta;
    logic [DELTA_W-1:0] mon_light_delta;
    logic [DELTA_W-1:0] mon_accel_delta;
    logic [DELTA_W-1:0] low_temp_delta;
    logic [DELTA_W-1:0] low_light_delta;
    logic [DELTA_W-1:0] recover_temp_delta;
  } apm_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POWER_W-1:0] power_state;
    logic [COUNT_W-1:0] activity_count;
    logic [PHASE_W-1:0] cycle_phase;
  } apm_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]    next_mode;
    logic [POWER_W-1:0]   power_level;
    logic [CURRENT_W-1:0] est_current_ua;
    logic [COUNT_W-1:0]   activity_level;
    logic                 activity_seen;
  } apm_res_t;

  // Table current for each power level.
  function automatic logic [CURRENT_W-1:0] current_for(input logic [POWER_W-1:0] p);
    logic [CURRENT_W-1:0] c;
    case (p)
      PWR_ACTIVE: c = 15'd20000;
      PWR_IDLE:   c = 15'd8000;
      PWR_SENSOR: c = 15'd3000;
      PWR_DEEP:   c = 15'd50;
      PWR_EMERG:  c = 15'd10;
      default:    c = '0;
    endcase
    return c;
  endfunction

  // Phase is a multiple of three.
  function automatic logic phase_mult3(input logic [PHASE_W-1:0] ph);
    logic r;
    case (ph) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Phase is a multiple of ten.
  function automatic logic phase_mult10(input logic [PHASE_W-1:0] ph);
    logic r;
    case (ph) inside
      5'd0, 5'd10, 5'd20: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Phase is a multiple of fifteen.
  function automatic logic phase_mult15(input logic [PHASE_W-1:0] ph);
    logic r;
    case (ph) inside
      5'd0, 5'd15: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/apm_in_if.sv */
interface apm_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] temp_sample;
  logic [SAMPLE_BITS-1:0] light_sample;
  logic [SAMPLE_BITS-1:0] accel_sample;

  modport source (output valid, output temp_sample, output light_sample,
                  output accel_sample, input ready);
  modport sink (input valid, input temp_sample, input light_sample,
                input accel_sample, output ready);
endinterface

/* rtl/apm_out_if.sv */
interface apm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  next_mode;
  logic [2:0]  power_level;
  logic [14:0] est_current_ua;
  logic [15:0] activity_level;
  logic        activity_seen;

  modport source (output valid, output next_mode, output power_level,
                  output est_current_ua, output activity_level,
                  output activity_seen, input ready);
  modport sink (input valid, input next_mode, input power_level,
                input est_current_ua, input activity_level,
                input activity_seen, output ready);
endinterface

/* rtl/activity_power_mode_controller.sv */
// An accepted item is held in the input register; its result is registered in the
// result register when the item advances, which waits while a result is held unread.
// One item per cycle while out_o.ready is high; the mode, count and baseline update is one
// pass of logic between the input register and the result register.
// Reset (rst_ni low, asynchronous): startup mode, active power, count, phase and
// baselines at zero, registers at their reset values, both channels empty.
module activity_power_mode_controller
  import apm_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  apm_in_if.sink            in_i,
  apm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  apm_cfg_t               cfg;
  apm_state_t             st_q, st_d;
  apm_res_t               res_q, res_d;
  logic [SAMPLE_BITS-1:0] base_t_q, base_l_q, base_a_q;
  logic [SAMPLE_BITS-1:0] base_t_d, base_l_d, base_a_d;
  logic [SAMPLE_BITS-1:0] t_q, l_q, a_q;
  logic                   in_valid_q, out_valid_q;
  logic                   advance, in_take;

  apm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apm_step #(.SAMPLE_BITS(SAMPLE_BITS)) u_step (
    .cfg_i    (cfg),
    .st_i     (st_q),
    .base_t_i (base_t_q),
    .base_l_i (base_l_q),
    .base_a_i (base_a_q),
    .t_i      (t_q),
    .l_i      (l_q),
    .a_i      (a_q),
    .st_o     (st_d),
    .base_t_o (base_t_d),
    .base_l_o (base_l_d),
    .base_a_o (base_a_d),
    .res_o    (res_d)
  );

  // Handshake: the held item moves on when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      t_q <= in_i.temp_sample;
      l_q <= in_i.light_sample;
      a_q <= in_i.accel_sample;
    end
  end

  // Controller state, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode           <= MODE_STARTUP;
      st_q.power_state    <= PWR_ACTIVE;
      st_q.activity_count <= '0;
      st_q.cycle_phase    <= '0;
      base_t_q            <= '0;
      base_l_q            <= '0;
      base_a_q            <= '0;
    end else if (advance) begin
      st_q     <= st_d;
      base_t_q <= base_t_d;
      base_l_q <= base_l_d;
      base_a_q <= base_a_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.next_mode      = res_q.next_mode;
  assign out_o.power_level    = res_q.power_level;
  assign out_o.est_current_ua = res_q.est_current_ua;
  assign out_o.activity_level = res_q.activity_level;
  assign out_o.activity_seen  = res_q.activity_seen;

endmodule

/* rtl/apm_regs.sv */
module apm_regs
  import apm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output apm_cfg_t          cfg_o
);

  apm_cfg_t            cfg_q;
  logic                wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_AW-1:2];
  assign cfg_o  = cfg_q;

  // Register writes; each register keeps only its own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emergency_limit    <= RST_EMERG_LIMIT;
      cfg_q.low_activity_limit <= RST_LOW_LIMIT;
      cfg_q.mon_temp_delta     <= RST_MON_TEMP;
      cfg_q.mon_light_delta    <= RST_MON_LIGHT;
      cfg_q.mon_accel_delta    <= RST_MON_ACCEL;
      cfg_q.low_temp_delta     <= RST_LOW_TEMP;
      cfg_q.low_light_delta    <= RST_LOW_LIGHT;
      cfg_q.recover_temp_delta <= RST_RECOVER_TEMP;
    end else if (wr_en) begin
      case (idx)
        REG_EMERG_LIMIT:  cfg_q.emergency_limit    <= pwdata[COUNT_W-1:0];
        REG_LOW_LIMIT:    cfg_q.low_activity_limit <= pwdata[COUNT_W-1:0];
        REG_MON_TEMP:     cfg_q.mon_temp_delta     <= pwdata[DELTA_W-1:0];
        REG_MON_LIGHT:    cfg_q.mon_light_delta    <= pwdata[DELTA_W-1:0];
        REG_MON_ACCEL:    cfg_q.mon_accel_delta    <= pwdata[DELTA_W-1:0];
        REG_LOW_TEMP:     cfg_q.low_temp_delta     <= pwdata[DELTA_W-1:0];
        REG_LOW_LIGHT:    cfg_q.low_light_delta    <= pwdata[DELTA_W-1:0];
        REG_RECOVER_TEMP: cfg_q.recover_temp_delta <= pwdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_EMERG_LIMIT:  prdata = APB_DW'(cfg_q.emergency_limit);
      REG_LOW_LIMIT:    prdata = APB_DW'(cfg_q.low_activity_limit);
      REG_MON_TEMP:     prdata = APB_DW'(cfg_q.mon_temp_delta);
      REG_MON_LIGHT:    prdata = APB_DW'(cfg_q.mon_light_delta);
      REG_MON_ACCEL:    prdata = APB_DW'(cfg_q.mon_accel_delta);
      REG_LOW_TEMP:     prdata = APB_DW'(cfg_q.low_temp_delta);
      REG_LOW_LIGHT:    prdata = APB_DW'(cfg_q.low_light_delta);
      REG_RECOVER_TEMP: prdata = APB_DW'(cfg_q.recover_temp_delta);
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/apm_step.sv */
module apm_step
  import apm_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  apm_cfg_t               cfg_i,
  input  apm_state_t             st_i,
  input  logic [SAMPLE_BITS-1:0] base_t_i,
  input  logic [SAMPLE_BITS-1:0] base_l_i,
  input  logic [SAMPLE_BITS-1:0] base_a_i,
  input  logic [SAMPLE_BITS-1:0] t_i,
  input  logic [SAMPLE_BITS-1:0] l_i,
  input  logic [SAMPLE_BITS-1:0] a_i,
  output apm_state_t             st_o,
  output logic [SAMPLE_BITS-1:0] base_t_o,
  output logic [SAMPLE_BITS-1:0] base_l_o,
  output logic [SAMPLE_BITS-1:0] base_a_o,
  output apm_res_t               res_o
);

  // Compare width covers both the samples and the configured deltas.
  localparam int AW = (SAMPLE_BITS > DELTA_W) ? SAMPLE_BITS : DELTA_W;
  localparam int TW = SAMPLE_BITS + 2;

  logic [AW-1:0]        dt, dl, da;
  logic [AW-1:0]        mt, ml, ma, lt, ll, rt;
  logic [COUNT_W-1:0]   cnt, cnt_mon, cnt_low, cnt_rec, cnt_maint;
  logic [COUNT_W:0]     sum2, sum_rec, sum_half;
  logic [PHASE_W-1:0]   phase, phase_nxt;
  logic                 hit_mon, hit_low, hit_rec;
  logic [TW-1:0]        trk_t, trk_l, trk_a;
  logic [MODE_W-1:0]    mode_nxt;
  logic [POWER_W-1:0]   pwr_nxt;
  logic [COUNT_W-1:0]   cnt_nxt;
  logic                 seen;

  // Absolute deviations from the baselines.
  always_comb begin
    dt = (t_i > base_t_i) ? AW'(t_i - base_t_i) : AW'(base_t_i - t_i);
    dl = (l_i > base_l_i) ? AW'(l_i - base_l_i) : AW'(base_l_i - l_i);
    da = (a_i > base_a_i) ? AW'(a_i - base_a_i) : AW'(base_a_i - a_i);
    mt = AW'(cfg_i.mon_temp_delta);
    ml = AW'(cfg_i.mon_light_delta);
    ma = AW'(cfg_i.mon_accel_delta);
    lt = AW'(cfg_i.low_temp_delta);
    ll = AW'(cfg_i.low_light_delta);
    rt = AW'(cfg_i.recover_temp_delta);
  end

  assign phase   = (st_i.cycle_phase > PHASE_LAST) ? '0 : st_i.cycle_phase;
  assign hit_mon = (dt > mt) || (dl > ml) || (da > ma);
  assign hit_low = phase_mult3(phase) && ((dt > lt) || (dl > ll));
  assign hit_rec = dt > rt;

  // Candidate counts for each mode.
  always_comb begin
    cnt      = st_i.activity_count;
    sum2     = {1'b0, cnt} + (COUNT_W+1)'(2);
    sum_rec  = {1'b0, cfg_i.low_activity_limit} + (COUNT_W+1)'(2);
    sum_half = {1'b0, cnt} + (COUNT_W+1)'(1);
    if (hit_mon) begin
      cnt_mon = (&cnt) ? cnt : cnt + COUNT_W'(1);
    end else begin
      cnt_mon = (cnt == '0) ? cnt : cnt - COUNT_W'(1);
    end
    cnt_low   = !hit_low ? cnt : (sum2[COUNT_W] ? '1 : sum2[COUNT_W-1:0]);
    cnt_rec   = sum_rec[COUNT_W] ? '1 : sum_rec[COUNT_W-1:0];
    cnt_maint = phase_mult10(phase) ? sum_half[COUNT_W:1] : cnt;
  end

  // Baseline tracking (3b+x)/4.
  assign trk_t = ((TW'(base_t_i) << 1) + TW'(base_t_i) + TW'(t_i)) >> 2;
  assign trk_l = ((TW'(base_l_i) << 1) + TW'(base_l_i) + TW'(l_i)) >> 2;
  assign trk_a = ((TW'(base_a_i) << 1) + TW'(base_a_i) + TW'(a_i)) >> 2;

  // Mode machine.
  always_comb begin
    mode_nxt = st_i.mode;
    pwr_nxt  = st_i.power_state;
    cnt_nxt  = cnt;
    seen     = 1'b0;
    base_t_o = base_t_i;
    base_l_o = base_l_i;
    base_a_o = base_a_i;
    case (st_i.mode)
      MODE_MONITOR: begin
        pwr_nxt  = PWR_SENSOR;
        seen     = hit_mon;
        cnt_nxt  = cnt_mon;
        if (cnt_mon <= cfg_i.emergency_limit) begin
          mode_nxt = MODE_EMERG;
        end else if (cnt_mon <= cfg_i.low_activity_limit) begin
          mode_nxt = MODE_LOW;
        end
        base_t_o = trk_t[SAMPLE_BITS-1:0];
        base_l_o = trk_l[SAMPLE_BITS-1:0];
        base_a_o = trk_a[SAMPLE_BITS-1:0];
      end
      MODE_LOW: begin
        pwr_nxt = PWR_IDLE;
        seen    = hit_low;
        cnt_nxt = cnt_low;
        if (cnt_low > cfg_i.low_activity_limit) begin
          mode_nxt = MODE_MONITOR;
        end else if (cnt_low <= cfg_i.emergency_limit) begin
          mode_nxt = MODE_EMERG;
        end
      end
      MODE_EMERG: begin
        pwr_nxt = PWR_EMERG;
        if (hit_rec) begin
          seen     = 1'b1;
          cnt_nxt  = cnt_rec;
          mode_nxt = MODE_MONITOR;
        end
      end
      MODE_MAINT: begin
        cnt_nxt  = cnt_maint;
        mode_nxt = MODE_MONITOR;
      end
      default: begin
        pwr_nxt  = PWR_ACTIVE;
        base_t_o = t_i;
        base_l_o = l_i;
        base_a_o = a_i;
        mode_nxt = MODE_MONITOR;
      end
    endcase
  end

  // Phase advance and forced maintenance.
  assign phase_nxt = (phase == PHASE_LAST) ? '0 : phase + PHASE_W'(1);

  always_comb begin
    st_o.mode           = phase_mult15(phase_nxt) ? MODE_MAINT : mode_nxt;
    st_o.power_state    = pwr_nxt;
    st_o.activity_count = cnt_nxt;
    st_o.cycle_phase    = phase_nxt;
    res_o.next_mode      = st_o.mode;
    res_o.power_level    = pwr_nxt;
    res_o.est_current_ua = current_for(pwr_nxt);
    res_o.activity_level = cnt_nxt;
    res_o.activity_seen  = seen;
  end

endmodule
